[hdl/bsu_pkg.sv]
`timescale 1ns / 1ps
// bsu_pkg: shared types and constants of the byte string sorter
// used by the top level and by the port checker; no dependencies

package bsu_pkg;

	localparam int CH_W = 8;

	typedef logic signed [CH_W-1:0] ch_t;

endpackage

[hdl/bsu_ram.sv]
`timescale 1ns / 1ps
// bsu_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies; contents are undefined until written

module bsu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/byte_string_sorter_unit.sv]
`timescale 1ns / 1ps
// byte_string_sorter_unit: sorts the characters of one string by signed value
// depends on bsu_pkg and bsu_ram
//
// usage:
//   s_axis carries one character per item in tdata, tlast marks the final
//   character of the string. characters beyond MAX_LEN are dropped and the
//   string is flagged as overflowed.
//   m_axis returns every stored character in ascending signed order, one per
//   item, tlast on the final one, tuser set on every item of an overflowed
//   string.
// operation:
//   loading stores the characters in arrival order. after the final character the
//   block makes one pass over the character ram per distinct value, each pass
//   reading all n stored characters, and emits each value once per occurrence,
//   one item per cycle while m_axis_tready is high.
//   s_axis_tready is high only while a string is being loaded.
// reset: clears the fill count, the overflow flag and the output valid.
// stall: a low m_axis_tready freezes the output register and the emitting sequencer;
//   the last item of a string may wait while the next string loads.

module byte_string_sorter_unit #(
	parameter int MAX_LEN = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [bsu_pkg::CH_W-1:0]   s_axis_tdata,  // [7:0] ch
	input  logic                       s_axis_tlast,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [bsu_pkg::CH_W-1:0]   m_axis_tdata,  // [7:0] sorted_ch
	output logic                       m_axis_tlast,
	output logic                       m_axis_tuser   // [0] overflow
);

	import bsu_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam int AW = $clog2(MAX_LEN);

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic [CW-1:0] idx_q;
	logic          rvld_s1;
	logic          first_q;
	logic          found_q;
	ch_t           prev_q;
	ch_t           best_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] rem_q;

	logic          out_vld_q;
	ch_t           out_ch_q;
	logic          out_last_q;
	logic          out_ovf_q;

	logic          in_acc;
	logic          room;
	logic          ram_we;
	logic [CH_W-1:0] ram_rdata;
	ch_t           rd_ch;
	logic          cand;
	logic          load_out;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = fill_q < CW'(MAX_LEN);
	assign ram_we        = in_acc && room;
	assign rd_ch         = ch_t'(ram_rdata);
	assign cand          = rvld_s1 && (first_q || (rd_ch > prev_q));
	assign load_out      = (state_q == ST_EMIT) && (!out_vld_q || m_axis_tready);

	bsu_ram #(
		.WIDTH(CH_W),
		.DEPTH(MAX_LEN)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(fill_q[AW-1:0]),
		.wdata(s_axis_tdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			idx_q   <= '0;
			rvld_s1 <= 1'b0;
			first_q <= 1'b1;
			found_q <= 1'b0;
			cnt_q   <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (room) begin
							fill_q <= fill_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (s_axis_tlast) begin
							state_q <= ST_SCAN;
							rem_q   <= fill_q + CW'(room);
							idx_q   <= '0;
							rvld_s1 <= 1'b0;
							first_q <= 1'b1;
							found_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					rvld_s1 <= idx_q < fill_q;
					if (idx_q < fill_q) begin
						idx_q <= idx_q + CW'(1);
					end
					if (cand && (!found_q || rd_ch < best_q)) begin
						best_q  <= rd_ch;
						cnt_q   <= CW'(1);
						found_q <= 1'b1;
					end else if (cand && rd_ch == best_q) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (idx_q == fill_q && !rvld_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load_out) begin
						cnt_q <= cnt_q - CW'(1);
						rem_q <= rem_q - CW'(1);
						if (cnt_q == CW'(1)) begin
							if (rem_q == CW'(1)) begin
								state_q <= ST_LOAD;
								fill_q  <= '0;
								ovf_q   <= 1'b0;
							end else begin
								state_q <= ST_SCAN;
								prev_q  <= best_q;
								first_q <= 1'b0;
								found_q <= 1'b0;
								idx_q   <= '0;
								rvld_s1 <= 1'b0;
							end
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_ch_q   <= best_q;
			out_last_q <= (rem_q == CW'(1));
			out_ovf_q  <= ovf_q;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_ch_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

endmodule

[hdl/bsu_checker.sv]
`timescale 1ns / 1ps
// bsu_checker: port-level checks of the byte string sorter output stream
// depends on bsu_pkg; bound to byte_string_sorter_unit below

module bsu_checker #(
	parameter int MAX_LEN = 64
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     m_axis_tvalid,
	input logic                     m_axis_tready,
	input logic [bsu_pkg::CH_W-1:0] m_axis_tdata,
	input logic                     m_axis_tlast
);

	import bsu_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	logic          out_acc;
	logic          in_frame_q;
	ch_t           prev_q;
	logic [CW-1:0] cnt_q;

	assign out_acc = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			cnt_q      <= '0;
		end else if (out_acc) begin
			in_frame_q <= !m_axis_tlast;
			cnt_q      <= m_axis_tlast ? '0 : cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (out_acc) begin
			prev_q <= ch_t'(m_axis_tdata);
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output valid dropped while stalled");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output item changed while stalled");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && in_frame_q |-> ch_t'(m_axis_tdata) >= prev_q)
		else $error("output items not in ascending order");

	a_frame_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> cnt_q < CW'(MAX_LEN))
		else $error("more items in one string than capacity");

endmodule

bind byte_string_sorter_unit bsu_checker #(
	.MAX_LEN(MAX_LEN)
) u_bsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// tb_top: self-checking testbench of byte_string_sorter_unit
// streams strings in, predicts each sorted result and checks every output item
// depends on bsu_pkg and byte_string_sorter_unit

module tb_top;

	import bsu_pkg::*;

	localparam int STR_CAP = 64;

	typedef struct {
		ch_t ch;
		bit  last;
		bit  ovf;
	} sorted_item_t;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_axis_tvalid = 1'b0;
	logic            s_axis_tready;
	logic [CH_W-1:0] s_axis_tdata = '0;
	logic            s_axis_tlast = 1'b0;
	logic            m_axis_tvalid;
	logic            m_axis_tready = 1'b0;
	logic [CH_W-1:0] m_axis_tdata;
	logic            m_axis_tlast;
	logic            m_axis_tuser;

	sorted_item_t sorted_q[$];
	ch_t          word_chars[$];
	bit           word_ovf = 1'b0;

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int n_errors = 0;
	int n_words = 0;
	int n_ovf_words = 0;
	int n_chars_in = 0;
	int n_checked = 0;

	byte_string_sorter_unit #(
		.MAX_LEN(STR_CAP)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sorted insert of each stored char, release of the whole word on the mark
	task automatic predict_char(input ch_t c, input bit lst);
		int i;
		sorted_item_t it;
		i = 0;
		if (word_chars.size() < STR_CAP) begin
			while (i < word_chars.size() && word_chars[i] <= c)
				i++;
			word_chars.insert(i, c);
		end else begin
			word_ovf = 1'b1;
		end
		if (lst) begin
			for (i = 0; i < word_chars.size(); i++) begin
				it.ch   = word_chars[i];
				it.last = (i == word_chars.size() - 1);
				it.ovf  = word_ovf;
				sorted_q.push_back(it);
			end
			n_words++;
			if (word_ovf)
				n_ovf_words++;
			word_chars.delete();
			word_ovf = 1'b0;
		end
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic load_char(input ch_t c, input bit lst);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tlast  <= lst;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_char(c, lst);
		n_chars_in++;
		@(negedge clk);
	endtask

	task automatic load_random_word(input int len);
		int i;
		for (i = 0; i < len; i++)
			load_char(ch_t'($urandom_range(0, 255)), i == len - 1);
	endtask

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);

	always @(posedge clk) begin
		sorted_item_t exp_item;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (sorted_q.size() == 0) begin
				$error("unexpected item: sorted_ch %0d", $signed(m_axis_tdata));
				n_errors++;
			end else begin
				exp_item = sorted_q.pop_front();
				n_checked++;
				if (m_axis_tdata !== exp_item.ch) begin
					$error("sorted_ch mismatch: expected %0d, got %0d",
						exp_item.ch, $signed(m_axis_tdata));
					n_errors++;
				end
				if (m_axis_tlast !== exp_item.last) begin
					$error("last_out mismatch: expected %0d, got %0d",
						exp_item.last, m_axis_tlast);
					n_errors++;
				end
				if (m_axis_tuser !== exp_item.ovf) begin
					$error("overflow mismatch: expected %0d, got %0d",
						exp_item.ovf, m_axis_tuser);
					n_errors++;
				end
			end
		end
	end

	// single chars, extremes, zeros, duplicates and a descending run
	task automatic test_directed();
		ch_t vals[20];
		bit  ends[20];
		int  i;
		vals = '{127, -128, 0, 127, -128, 0, -1, 1, 0, 0, 0,
			5, -5, 5, -5, 5, -1, -2, -3, -4};
		ends = '{1, 1, 1, 0, 0, 0, 0, 1, 0, 0, 1,
			0, 0, 0, 0, 1, 0, 0, 0, 1};
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		for (i = 0; i < 20; i++)
			load_char(vals[i], ends[i]);
	endtask

	// a word that fills the store and whose marked char is dropped
	task automatic test_overflow();
		load_random_word(STR_CAP + 1);
	endtask

	task automatic test_random(input int idle_pct, input int stall_pct, input int n_items);
		int sent;
		int len;
		sent = 0;
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		while (sent < n_items) begin
			len = $urandom_range(1, 8);
			load_random_word(len);
			sent += len;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_overflow();
		test_random(0, 0, 16);
		test_random(47, 0, 16);
		test_random(0, 47, 16);
		test_random(6, 6, 16);
		s_axis_tvalid <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d strings (%0d overflowed), %0d chars loaded, %0d sorted items checked",
			n_words, n_ovf_words, n_chars_in, n_checked);
		$display("phases: directed, full store, no idle, sender gaps, receiver stalls, mixed");
		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d items still expected", sorted_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[files.f]
hdl/bsu_pkg.sv
hdl/bsu_ram.sv
hdl/byte_string_sorter_unit.sv
hdl/bsu_checker.sv
verif/tb_top.sv
